// File: hw/rtl/stfc_pkg.sv
package stfc_pkg;

  // Tilemap row stride in entries
  localparam int MAP_WIDTH = 32;

  // Row store: two banks of eight rows
  localparam int ROW_W       = 32;
  localparam int INDEX_W     = 10;
  localparam int BANK_ROWS   = 8;
  localparam int STORE_DEPTH = 2 * BANK_ROWS;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // Tile descriptor queue and result queue depths
  localparam int DESC_DEPTH = 2;
  localparam int OUT_DEPTH  = 4;

  // Configuration register indexes
  localparam logic [0:0] REG_SHAPE = 1'b0;
  localparam logic [0:0] REG_SIZE  = 1'b1;

  // Sprite shape codes
  localparam logic [1:0] SHAPE_SQUARE = 2'd0;
  localparam logic [1:0] SHAPE_WIDE   = 2'd1;
  localparam logic [1:0] SHAPE_TALL   = 2'd2;

  // One completed tile, handed from the front to the back
  typedef struct packed {
    logic               bank;
    logic               xflip;
    logic               yflip;
    logic [INDEX_W-1:0] index;
    logic [5:0]         tile_num;
    logic [7:0]         map_offset;
    logic               last;
  } tile_desc_t;

  // Bank handed back to the front once its last row is read
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  // One result request
  typedef struct packed {
    logic [ROW_W-1:0] dest_row;
    logic [10:0]      dest_offset;
    logic [14:0]      source_offset;
    logic [7:0]       map_offset;
    logic             tile_done;
    logic             sprite_done;
  } out_item_t;

  // Sprite width and height in tiles as log2, packed {wlog, hlog}
  function automatic logic [3:0] sprite_dims_log2(input logic [1:0] shape,
                                                  input logic [1:0] size);
    logic [3:0] r;
    case (shape)
      SHAPE_SQUARE: r = {size, size};
      SHAPE_WIDE: begin
        case (size)
          2'd0:    r = {2'd1, 2'd0};
          2'd1:    r = {2'd2, 2'd0};
          2'd2:    r = {2'd2, 2'd1};
          default: r = {2'd3, 2'd2};
        endcase
      end
      SHAPE_TALL: begin
        case (size)
          2'd0:    r = {2'd0, 2'd1};
          2'd1:    r = {2'd0, 2'd2};
          2'd2:    r = {2'd1, 2'd2};
          default: r = {2'd2, 2'd3};
        endcase
      end
      default: r = {size, size};
    endcase
    return r;
  endfunction

  // Reverse the eight nibbles of a row
  function automatic logic [ROW_W-1:0] nibble_reverse(input logic [ROW_W-1:0] r);
    logic [ROW_W-1:0] o;
    o = '0;
    for (int n = 0; n < 8; n++) begin
      o[4*(7-n) +: 4] = r[4*n +: 4];
    end
    return o;
  endfunction

endpackage

// File: hw/rtl/stfc_ram.sv
module stfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/stfc_front.sv
module stfc_front import stfc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // row input
  input  logic                push,
  output logic                full,
  input  logic [ROW_W-1:0]    source_row,
  input  logic [15:0]         map_entry,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [1:0]          cfg_data,
  // row store write port
  output logic                store_we,
  output logic [STORE_AW-1:0] store_waddr,
  output logic [ROW_W-1:0]    store_wdata,
  // tile descriptor queue
  output tile_desc_t          desc,
  output logic                desc_push,
  input  logic                desc_full,
  input  bank_rel_t           bank_rel
);

  logic [2:0]         row_counter;
  logic [2:0]         tile_column;
  logic [2:0]         tile_line;
  logic [1:0]         latched_flips;
  logic [INDEX_W-1:0] latched_index;
  logic [1:0]         sprite_shape;
  logic [1:0]         sprite_size;
  logic               wbank;
  logic [1:0]         bank_busy;
  logic [1:0]         bank_busy_next;

  logic               accept;
  logic               first_row;
  logic [INDEX_W-1:0] cur_index;
  logic [1:0]         cur_flips;
  logic [3:0]         dims;
  logic [1:0]         wlog;
  logic [1:0]         hlog;
  logic [3:0]         w;
  logic [3:0]         h;
  logic               last_col;
  logic               last_line;
  logic [11:0]        map_prod;

  assign cfg_ready = 1'b1;
  assign full      = bank_busy[wbank] || desc_full;
  assign accept    = push && !full;
  assign first_row = (row_counter == 3'd0);

  // Take the tilemap entry on row 0, hold it for the rest of the tile
  assign cur_index = first_row ? map_entry[INDEX_W-1:0] : latched_index;
  assign cur_flips = first_row ? map_entry[11:10] : latched_flips;

  // Write each row into the current bank
  assign store_we    = accept;
  assign store_waddr = {wbank, row_counter};
  assign store_wdata = source_row;

  // Sprite geometry and tile position
  assign dims      = sprite_dims_log2(sprite_shape, sprite_size);
  assign wlog      = dims[3:2];
  assign hlog      = dims[1:0];
  assign w         = 4'd1 << wlog;
  assign h         = 4'd1 << hlog;
  assign last_col  = ({1'b0, tile_column} + 4'd1) >= w;
  assign last_line = ({1'b0, tile_line} + 4'd1) >= h;
  assign map_prod  = 12'(tile_line) * 12'(MAP_WIDTH) + 12'(tile_column);

  // Describe the finished tile on its eighth row
  always_comb begin
    desc.bank       = wbank;
    desc.xflip      = cur_flips[0];
    desc.yflip      = cur_flips[1];
    desc.index      = cur_index;
    desc.tile_num   = 6'({3'b000, tile_line} << wlog) + 6'(tile_column);
    desc.map_offset = map_prod[7:0];
    desc.last       = last_col && last_line;
  end

  assign desc_push = accept && (row_counter == 3'd7);

  // Set a bank busy when its tile is queued, drop it when the back is done
  always_comb begin
    bank_busy_next = bank_busy;
    if (bank_rel.valid) begin
      bank_busy_next[bank_rel.bank] = 1'b0;
    end
    if (desc_push) begin
      bank_busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter   <= '0;
      tile_column   <= '0;
      tile_line     <= '0;
      latched_flips <= '0;
      latched_index <= '0;
      sprite_shape  <= '0;
      sprite_size   <= '0;
      wbank         <= 1'b0;
      bank_busy     <= '0;
    end else begin
      bank_busy <= bank_busy_next;
      // Register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SHAPE: sprite_shape <= cfg_data;
          REG_SIZE:  sprite_size  <= cfg_data;
          default:   ;
        endcase
      end
      // Advance row and tile position
      if (accept) begin
        latched_index <= cur_index;
        latched_flips <= cur_flips;
        row_counter   <= row_counter + 3'd1;
        if (row_counter == 3'd7) begin
          wbank <= ~wbank;
          if (last_col) begin
            tile_column <= '0;
            tile_line   <= last_line ? 3'd0 : tile_line + 3'd1;
          end else begin
            tile_column <= tile_column + 3'd1;
          end
        end
      end
    end
  end

`ifndef SYNTH
  a_write_free_bank: assert property (@(posedge clk) disable iff (rst)
    accept |-> !bank_busy[wbank])
    else $error("row written into a bank still being read");
  a_release_busy: assert property (@(posedge clk) disable iff (rst)
    bank_rel.valid |-> bank_busy[bank_rel.bank])
    else $error("release of a bank that was not busy");
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    desc_push |-> !desc_full)
    else $error("tile queued while descriptor queue full");
`endif

endmodule

// File: hw/rtl/stfc_desc_queue.sv
module stfc_desc_queue import stfc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  tile_desc_t push_desc,
  output logic       full,
  input  logic       pop,
  output tile_desc_t head,
  output logic       empty
);

  localparam int PTR_W = $clog2(DESC_DEPTH);
  localparam int CNT_W = $clog2(DESC_DEPTH + 1);

  tile_desc_t       mem [DESC_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DESC_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  // Store descriptors
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DESC_DEPTH))
    else $error("descriptor queue count out of range");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("descriptor queue count lost a push");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    empty |-> (wr_ptr == rd_ptr))
    else $error("descriptor queue pointers disagree when empty");
`endif

endmodule

// File: hw/rtl/stfc_back.sv
module stfc_back import stfc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // tile descriptor queue
  input  tile_desc_t          q_desc,
  input  logic                q_empty,
  output logic                q_pop,
  // row store read port
  output logic                store_re,
  output logic [STORE_AW-1:0] store_raddr,
  input  logic [ROW_W-1:0]    store_rdata,
  output bank_rel_t           bank_rel,
  // result output
  output logic                empty,
  input  logic                pop,
  output logic [ROW_W-1:0]    dest_row,
  output logic [10:0]         dest_offset,
  output logic [14:0]         source_offset,
  output logic [7:0]          map_offset,
  output logic                tile_done,
  output logic                sprite_done
);

  localparam int OUT_AW = $clog2(OUT_DEPTH);
  localparam int OUT_CW = $clog2(OUT_DEPTH + 1);

  logic              active;
  tile_desc_t        cur;
  logic [2:0]        k;
  logic              rd_valid;
  tile_desc_t        rd_desc;
  logic [2:0]        rd_k;

  out_item_t         fifo_mem [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr;
  logic [OUT_AW-1:0] rd_ptr;
  logic [OUT_CW-1:0] cnt;

  logic              credit_ok;
  logic              issue;
  logic              last_issue;
  logic              fifo_pop;
  out_item_t         new_item;
  out_item_t         head;

  // Issue a read only when the result queue has room for it
  assign credit_ok  = (cnt + OUT_CW'(rd_valid)) < OUT_CW'(OUT_DEPTH);
  assign issue      = active && credit_ok;
  assign last_issue = issue && (k == 3'd7);
  assign q_pop      = !q_empty && (!active || last_issue);

  // Walk the rows of the bank, reversed for y-flip
  assign store_re    = issue;
  assign store_raddr = {cur.bank, (cur.yflip ? ~k : k)};

  assign bank_rel.valid = last_issue;
  assign bank_rel.bank  = cur.bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      k        <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (issue) begin
        k <= k + 3'd1;
      end
      if (q_pop) begin
        active <= 1'b1;
        k      <= '0;
      end else if (last_issue) begin
        active <= 1'b0;
      end
    end
  end

  // Load the next tile and stage the read context
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_desc;
    end
    rd_desc <= cur;
    rd_k    <= k;
  end

  // Build the result request from the read row
  always_comb begin
    new_item.dest_row      = rd_desc.xflip ? nibble_reverse(store_rdata) : store_rdata;
    new_item.dest_offset   = {rd_desc.tile_num, rd_k, 2'b00};
    new_item.source_offset = {rd_desc.index, 5'b00000};
    new_item.map_offset    = rd_desc.map_offset;
    new_item.tile_done     = (rd_k == 3'd7);
    new_item.sprite_done   = (rd_k == 3'd7) && rd_desc.last;
  end

  // Result queue
  assign empty    = (cnt == '0);
  assign fifo_pop = pop && !empty;
  assign head     = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      fifo_mem[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (rd_valid) begin
        wr_ptr <= wr_ptr + OUT_AW'(1);
      end
      if (fifo_pop) begin
        rd_ptr <= rd_ptr + OUT_AW'(1);
      end
      cnt <= cnt + OUT_CW'(rd_valid) - OUT_CW'(fifo_pop);
    end
  end

  assign dest_row      = head.dest_row;
  assign dest_offset   = head.dest_offset;
  assign source_offset = head.source_offset;
  assign map_offset    = head.map_offset;
  assign tile_done     = head.tile_done;
  assign sprite_done   = head.sprite_done;

`ifndef SYNTH
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (cnt + OUT_CW'(rd_valid)) <= OUT_CW'(OUT_DEPTH))
    else $error("result queue overrun");
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!active || (k == 3'd7)))
    else $error("tile loaded while previous tile unfinished");
  a_write_follows_issue: assert property (@(posedge clk) disable iff (rst)
    issue |=> rd_valid)
    else $error("issued read did not reach result queue");
  a_tile_done_order: assert property (@(posedge clk) disable iff (rst)
    (rd_valid && (rd_k == 3'd7)) |-> $past(last_issue))
    else $error("tile end out of order");
`endif

endmodule

// File: hw/rtl/sprite_tile_flip_copy.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------------------
// row in    | push / full          | source_row[31:0], map_entry[15:0]
// result    | empty / pop          | dest_row[31:0], dest_offset[10:0],
//           |                      | source_offset[14:0], map_offset[7:0],
//           |                      | tile_done, sprite_done
// config    | cfg_valid / cfg_ready| cfg_index[0:0], cfg_data[1:0]
//
// Rows are taken one per cycle while the bank to be written is free; each tile then yields
// eight result requests, one per cycle while the result queue has room, once the back
// has taken its descriptor. full holds while both row store banks wait to be read;
// at full rate the front meets a bank still being read every second tile and waits.
// A stalled pop fills the four-entry result queue and then holds row store reads.
// Synchronous active-high reset clears counters, position, registers and queues.
module sprite_tile_flip_copy import stfc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [ROW_W-1:0]   source_row,
  input  logic [15:0]        map_entry,
  output logic               empty,
  input  logic               pop,
  output logic [ROW_W-1:0]   dest_row,
  output logic [10:0]        dest_offset,
  output logic [14:0]        source_offset,
  output logic [7:0]         map_offset,
  output logic               tile_done,
  output logic               sprite_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [1:0]         cfg_data
);

  logic                store_we;
  logic [STORE_AW-1:0] store_waddr;
  logic [ROW_W-1:0]    store_wdata;
  logic                store_re;
  logic [STORE_AW-1:0] store_raddr;
  logic [ROW_W-1:0]    store_rdata;
  tile_desc_t          desc;
  logic                desc_push;
  logic                desc_full;
  tile_desc_t          q_desc;
  logic                q_empty;
  logic                q_pop;
  bank_rel_t           bank_rel;

  stfc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .source_row  (source_row),
    .map_entry   (map_entry),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .store_we    (store_we),
    .store_waddr (store_waddr),
    .store_wdata (store_wdata),
    .desc        (desc),
    .desc_push   (desc_push),
    .desc_full   (desc_full),
    .bank_rel    (bank_rel)
  );

  stfc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (STORE_DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  stfc_desc_queue u_desc_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (desc_push),
    .push_desc (desc),
    .full      (desc_full),
    .pop       (q_pop),
    .head      (q_desc),
    .empty     (q_empty)
  );

  stfc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_desc        (q_desc),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .store_re      (store_re),
    .store_raddr   (store_raddr),
    .store_rdata   (store_rdata),
    .bank_rel      (bank_rel),
    .empty         (empty),
    .pop           (pop),
    .dest_row      (dest_row),
    .dest_offset   (dest_offset),
    .source_offset (source_offset),
    .map_offset    (map_offset),
    .tile_done     (tile_done),
    .sprite_done   (sprite_done)
  );

endmodule
